### hdl/ccpe_pkg.sv
// Shared types and constants for the charger current pulse encoder.
// Used by ccpe_cfg_regs, ccpe_seq and charger_current_pulse_encoder.
`timescale 1ns / 1ps

package ccpe_pkg;

    localparam int CODE_BITS_DEF = 5;

    // Register indexes on the configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STOP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAP       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 3'd6;

    localparam logic [7:0] LEAD_HIGH_RST = 8'd1;
    localparam logic [7:0] LEAD_LOW_RST  = 8'd70;
    localparam logic [7:0] SHORT_RST     = 8'd40;
    localparam logic [7:0] LONG_RST      = 8'd90;
    localparam logic [7:0] STOP_RST      = 8'd160;
    localparam logic [7:0] GAP_RST       = 8'd30;
    localparam logic [7:0] SETTLE_RST    = 8'd100;

    // Accepted target window, in mV
    localparam logic [14:0] MIN_MV = 15'd5500;
    localparam logic [14:0] MAX_MV = 15'd21000;

    // Divide by 500 as (x * 8389) >> 22; exact for x up to 15500
    localparam logic [29:0] DIV500_MUL   = 30'd8389;
    localparam int          DIV500_SHIFT = 22;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD_HIGH,
        PH_LEAD_LOW,
        PH_BIT_FIRST,
        PH_BIT_SECOND,
        PH_STOP,
        PH_GAP,
        PH_SETTLE
    } phase_t;

    typedef struct packed {
        logic [7:0] lead_high_ms;
        logic [7:0] lead_low_ms;
        logic [7:0] short_ms;
        logic [7:0] long_ms;
        logic [7:0] stop_ms;
        logic [7:0] gap_ms;
        logic [7:0] settle_ms;
    } cfg_t;

    typedef struct packed {
        logic high_current;
        logic busy;
        logic done;
        logic rejected;
    } res_t;

    // Code value (target - 5500) / 500, eight bits wide
    function automatic logic [7:0] mv_to_code(input logic [14:0] mv);
        logic [14:0] diff;
        logic [29:0] prod;
        begin
            diff = mv - MIN_MV;
            prod = {15'd0, diff} * DIV500_MUL;
            mv_to_code = prod[DIV500_SHIFT+7:DIV500_SHIFT];
        end
    endfunction

endpackage

### hdl/ccpe_cfg_regs.sv
// Segment timing registers of the current pulse encoder.
// Depends on ccpe_pkg for register indexes and reset values.
`timescale 1ns / 1ps

module ccpe_cfg_regs
    import ccpe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_LEAD_HIGH: cfg_next.lead_high_ms = cfg_data;
                REG_LEAD_LOW:  cfg_next.lead_low_ms  = cfg_data;
                REG_SHORT:     cfg_next.short_ms     = cfg_data;
                REG_LONG:      cfg_next.long_ms      = cfg_data;
                REG_STOP:      cfg_next.stop_ms      = cfg_data;
                REG_GAP:       cfg_next.gap_ms       = cfg_data;
                REG_SETTLE:    cfg_next.settle_ms    = cfg_data;
                default:       cfg_next = cfg_reg;   // drop writes past the list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lead_high_ms <= LEAD_HIGH_RST;
            cfg_reg.lead_low_ms  <= LEAD_LOW_RST;
            cfg_reg.short_ms     <= SHORT_RST;
            cfg_reg.long_ms      <= LONG_RST;
            cfg_reg.stop_ms      <= STOP_RST;
            cfg_reg.gap_ms       <= GAP_RST;
            cfg_reg.settle_ms    <= SETTLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/ccpe_seq.sv
// Pattern sequencer: phase machine, millisecond counter, code word and level.
// Depends on ccpe_pkg for phase_t, cfg_t, res_t and the code conversion.
`timescale 1ns / 1ps

module ccpe_seq
    import ccpe_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic        req_type,
    input  logic [14:0] target_mv,
    input  cfg_t        cfg,
    output res_t        res
);

    localparam int BIT_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
    localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(CODE_BITS - 1);

    phase_t               phase_reg, phase_next;
    logic [BIT_W-1:0]     bit_index_reg, bit_index_next;
    logic [7:0]           ms_left_reg, ms_left_next;
    logic [CODE_BITS-1:0] code_word_reg, code_word_next;
    logic                 level_reg, level_next;

    logic       is_start;
    logic       in_range;
    logic       start_ok;
    logic       step;
    logic       new_bit;
    logic [7:0] code_full;

    assign is_start  = fire && !req_type;
    assign in_range  = (target_mv >= MIN_MV) && (target_mv <= MAX_MV);
    assign start_ok  = is_start && (phase_reg == PH_IDLE) && in_range;
    assign step      = fire && req_type && (phase_reg != PH_IDLE) && (ms_left_reg <= 8'd1);
    assign code_full = mv_to_code(target_mv);
    assign new_bit   = code_word_reg[bit_index_next];

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (start_ok)
        begin
            phase_next = PH_LEAD_HIGH;
        end
        else if (step)
        begin
            case (phase_reg)
                PH_LEAD_HIGH:  phase_next = PH_LEAD_LOW;
                PH_LEAD_LOW:   phase_next = PH_BIT_FIRST;
                PH_BIT_FIRST:  phase_next = PH_BIT_SECOND;
                PH_BIT_SECOND: phase_next = (bit_index_reg == '0) ? PH_STOP : PH_BIT_FIRST;
                PH_STOP:       phase_next = PH_GAP;
                PH_GAP:        phase_next = PH_SETTLE;
                default:       phase_next = PH_IDLE;
            endcase
        end
    end

    // Bit index; kept apart so the bit that a new segment sends is known
    always_comb
    begin
        bit_index_next = bit_index_reg;
        if (start_ok)
        begin
            bit_index_next = '0;
        end
        else if (step)
        begin
            case (phase_reg)
                PH_LEAD_LOW:   bit_index_next = BIT_TOP;
                PH_BIT_SECOND:
                begin
                    if (bit_index_reg != '0)
                        bit_index_next = bit_index_reg - 1'b1;
                end
                default:       bit_index_next = bit_index_reg;
            endcase
        end
    end

    // Segment load, counter and result
    always_comb
    begin
        ms_left_next   = ms_left_reg;
        level_next     = level_reg;
        code_word_next = code_word_reg;
        res.done       = 1'b0;
        res.rejected   = is_start && !start_ok;
        if (start_ok)
        begin
            code_word_next = code_full[CODE_BITS-1:0];
            ms_left_next   = cfg.lead_high_ms;
            level_next     = 1'b1;
        end
        else if (step)
        begin
            case (phase_reg)
                PH_LEAD_HIGH:
                begin
                    ms_left_next = cfg.lead_low_ms;
                    level_next   = 1'b0;
                end
                PH_LEAD_LOW:
                begin
                    ms_left_next = new_bit ? cfg.long_ms : cfg.short_ms;
                    level_next   = !new_bit;
                end
                PH_BIT_FIRST:
                begin
                    ms_left_next = new_bit ? cfg.short_ms : cfg.long_ms;
                    level_next   = new_bit;
                end
                PH_BIT_SECOND:
                begin
                    if (bit_index_reg == '0)
                    begin
                        ms_left_next = cfg.stop_ms;
                        level_next   = 1'b1;
                    end
                    else
                    begin
                        ms_left_next = new_bit ? cfg.long_ms : cfg.short_ms;
                        level_next   = !new_bit;
                    end
                end
                PH_STOP:
                begin
                    ms_left_next = cfg.gap_ms;
                    level_next   = 1'b0;
                end
                PH_GAP:
                begin
                    ms_left_next = cfg.settle_ms;
                    level_next   = 1'b1;
                end
                default:
                begin
                    // settle ran out: pattern complete
                    ms_left_next = 8'd0;
                    level_next   = 1'b1;
                    res.done     = 1'b1;
                end
            endcase
        end
        else if (fire && req_type && (phase_reg != PH_IDLE))
        begin
            ms_left_next = ms_left_reg - 8'd1;
        end
        res.high_current = level_next;
        res.busy         = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_index_reg <= '0;
            ms_left_reg   <= 8'd0;
            code_word_reg <= '0;
            level_reg     <= 1'b1;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            bit_index_reg <= bit_index_next;
            ms_left_reg   <= ms_left_next;
            code_word_reg <= code_word_next;
            level_reg     <= level_next;
        end
    end

endmodule

### hdl/charger_current_pulse_encoder.sv
// Charger current pulse encoder, top level: input stage, result register.
// Depends on ccpe_pkg, ccpe_cfg_regs and ccpe_seq.
//
// Usage: a transaction on the input channel is either a start (req_type 0,
// target_mv in mV) or a one millisecond tick (req_type 1). Every input
// transaction yields exactly one result transaction carrying high_current,
// busy_res, done_res and rejected, in order.
// The input stage registers each accepted transaction and the result register
// its result. Throughput: one transaction per cycle while out_stall is low, set
// by the single pass through the sequencer between these two registers.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are taken
// in every cycle; index 0..6 selects a segment length, other indexes are
// dropped. Write only while no transaction is in flight.
// Reset: the sequencer returns to idle with high current, timing registers
// take their defaults, both stages empty.
// Stall: while out_stall holds the result, one more transaction is taken
// into the input stage; after that in_stall rises until the result drains.
`timescale 1ns / 1ps

module charger_current_pulse_encoder
    import ccpe_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 req_type,
    input  logic [14:0]          target_mv,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 high_current,
    output logic                 busy_res,
    output logic                 done_res,
    output logic                 rejected,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    cfg_t cfg;
    res_t res;

    logic        stg_valid_reg;
    logic        stg_req_type_reg;
    logic [14:0] stg_target_mv_reg;
    logic        out_valid_reg;
    res_t        out_res_reg;

    logic in_accept;
    logic drain;
    logic fire;

    assign drain     = !out_valid_reg || !out_stall;
    assign fire      = stg_valid_reg && drain;
    assign in_stall  = stg_valid_reg && !drain;
    assign in_accept = in_valid && !in_stall;

    ccpe_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ccpe_seq #(
        .CODE_BITS (CODE_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .req_type  (stg_req_type_reg),
        .target_mv (stg_target_mv_reg),
        .cfg       (cfg),
        .res       (res)
    );

    // Input stage: hold the transaction until the sequencer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            stg_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stg_req_type_reg  <= req_type;
            stg_target_mv_reg <= target_mv;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (drain)
        begin
            out_valid_reg <= stg_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign high_current = out_res_reg.high_current;
    assign busy_res     = out_res_reg.busy;
    assign done_res     = out_res_reg.done;
    assign rejected     = out_res_reg.rejected;

endmodule

### test/ccpe_checker.sv
`timescale 1ns / 1ps
// Scoreboard for charger_current_pulse_encoder: tracks config writes, predicts
// the current level pattern per input transaction, compares every result.
// Depends on ccpe_pkg for register indexes, phase names and result layout.

module ccpe_checker
    import ccpe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 req_type,
    input  logic [14:0]          target_mv,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 high_current,
    input  logic                 busy_res,
    input  logic                 done_res,
    input  logic                 rejected,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output int                   errors,
    output int                   pending
);

    localparam int STEP_MV     = 500;
    localparam int MAX_REPORTS = 10;

    cfg_t                     seg_regs;
    phase_t                   ph;
    logic [2:0]               bit_ix;
    logic [7:0]               ms_left;
    logic [CODE_BITS_DEF-1:0] code;
    logic                     lvl;
    res_t                     pending_results[$];

    task automatic load_seg(input phase_t p, input logic [7:0] len, input logic l);
        ph = p;
        ms_left = len;
        lvl = l;
    endtask

    // Bit 1 opens with the long low segment, bit 0 with the short high one
    task automatic first_bit_seg();
        if (code[bit_ix])
            load_seg(PH_BIT_FIRST, seg_regs.long_ms, 1'b0);
        else
            load_seg(PH_BIT_FIRST, seg_regs.short_ms, 1'b1);
    endtask

    task automatic next_segment(output logic fin);
        fin = 1'b0;
        case (ph)
            PH_LEAD_HIGH: load_seg(PH_LEAD_LOW, seg_regs.lead_low_ms, 1'b0);
            PH_LEAD_LOW:
            begin
                bit_ix = 3'(CODE_BITS_DEF - 1);
                first_bit_seg();
            end
            PH_BIT_FIRST:
            begin
                if (code[bit_ix])
                    load_seg(PH_BIT_SECOND, seg_regs.short_ms, 1'b1);
                else
                    load_seg(PH_BIT_SECOND, seg_regs.long_ms, 1'b0);
            end
            PH_BIT_SECOND:
            begin
                if (bit_ix == 0)
                    load_seg(PH_STOP, seg_regs.stop_ms, 1'b1);
                else
                begin
                    bit_ix = bit_ix - 1'b1;
                    first_bit_seg();
                end
            end
            PH_STOP: load_seg(PH_GAP, seg_regs.gap_ms, 1'b0);
            PH_GAP:  load_seg(PH_SETTLE, seg_regs.settle_ms, 1'b1);
            default:
            begin
                load_seg(PH_IDLE, 8'd0, 1'b1);
                fin = 1'b1;
            end
        endcase
    endtask

    task automatic step_pattern(input logic rq, input logic [14:0] mv);
        res_t r;
        logic fin;
        int   q;
        r = '0;
        fin = 1'b0;
        if (rq == 1'b0)
        begin
            if (ph != PH_IDLE || mv < MIN_MV || mv > MAX_MV)
                r.rejected = 1'b1;
            else
            begin
                q = (int'(mv) - int'(MIN_MV)) / STEP_MV;
                code = q[CODE_BITS_DEF-1:0];
                bit_ix = '0;
                load_seg(PH_LEAD_HIGH, seg_regs.lead_high_ms, 1'b1);
            end
        end
        else if (ph != PH_IDLE)
        begin
            // A segment of length zero or one ends on this tick
            if (ms_left <= 8'd1)
                next_segment(fin);
            else
                ms_left = ms_left - 1'b1;
        end
        r.high_current = lvl;
        r.busy = (ph != PH_IDLE);
        r.done = fin;
        pending_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            seg_regs = {LEAD_HIGH_RST, LEAD_LOW_RST, SHORT_RST, LONG_RST,
                        STOP_RST, GAP_RST, SETTLE_RST};
            ph = PH_IDLE;
            bit_ix = '0;
            ms_left = '0;
            code = '0;
            lvl = 1'b1;
            pending_results.delete();
            errors = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result hc=%b busy=%b done=%b rej=%b",
                                 $time, high_current, busy_res, done_res, rejected);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (high_current !== want.high_current || busy_res !== want.busy ||
                        done_res !== want.done || rejected !== want.rejected)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: hc/busy/done/rej exp %b%b%b%b got %b%b%b%b",
                                     $time, want.high_current, want.busy, want.done,
                                     want.rejected, high_current, busy_res, done_res,
                                     rejected);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LEAD_HIGH: seg_regs.lead_high_ms = cfg_data;
                    REG_LEAD_LOW:  seg_regs.lead_low_ms = cfg_data;
                    REG_SHORT:     seg_regs.short_ms = cfg_data;
                    REG_LONG:      seg_regs.long_ms = cfg_data;
                    REG_STOP:      seg_regs.stop_ms = cfg_data;
                    REG_GAP:       seg_regs.gap_ms = cfg_data;
                    REG_SETTLE:    seg_regs.settle_ms = cfg_data;
                    default:       ;
                endcase
            end
            if (in_valid && !in_stall)
                step_pattern(req_type, target_mv);
        end
        pending = pending_results.size();
    end

endmodule

### test/charger_current_pulse_encoder_tb.sv
`timescale 1ns / 1ps
// Top of the charger_current_pulse_encoder testbench: clock, reset, stimulus
// and verdict. Depends on ccpe_pkg, the encoder RTL and ccpe_checker.

module charger_current_pulse_encoder_tb;
    import ccpe_pkg::*;

    localparam logic                 REQ_START   = 1'b0;
    localparam logic                 REQ_TICK    = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
    localparam int                   ITEMS       = 1450;
    localparam int                   HOLD_CYCLES = 300;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 req_type = 1'b0;
    logic [14:0]          target_mv = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 high_current;
    logic                 busy_res;
    logic                 done_res;
    logic                 rejected;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data = '0;

    int         chk_errors;
    int         pending;
    int         items_sent = 0;
    bit         no_gaps = 1'b0;
    bit         hold_go = 1'b0;
    int         hold_left = 0;
    logic [7:0] seg_ms[7];

    charger_current_pulse_encoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .target_mv    (target_mv),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .high_current (high_current),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .rejected     (rejected),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    ccpe_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .target_mv    (target_mv),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .high_current (high_current),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .rejected     (rejected),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (chk_errors),
        .pending      (pending)
    );

    always #5 clk = ~clk;

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_go)
            begin
                hold_go = 1'b0;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !no_gaps && ($urandom_range(99) < 7);
        end
    end

    initial
    begin
        #5_000_000;
        $display("** charger_current_pulse_encoder: FAILED **");
        $finish;
    end

    function automatic int ms_of(input logic [7:0] v);
        return (v == 8'd0) ? 1 : int'(v);
    endfunction

    function automatic int pattern_ticks();
        return ms_of(seg_ms[REG_LEAD_HIGH]) + ms_of(seg_ms[REG_LEAD_LOW]) +
               CODE_BITS_DEF * (ms_of(seg_ms[REG_SHORT]) + ms_of(seg_ms[REG_LONG])) +
               ms_of(seg_ms[REG_STOP]) + ms_of(seg_ms[REG_GAP]) +
               ms_of(seg_ms[REG_SETTLE]);
    endfunction

    function automatic logic [14:0] pick_target();
        case ($urandom_range(7))
            0:       return MIN_MV;
            1:       return MAX_MV;
            2:       return 15'd5999;
            3:       return 15'd6000;
            default: return 15'($urandom_range(MIN_MV, MAX_MV));
        endcase
    endfunction

    // Returns right after the accepting edge; the caller's next step lowers or reloads valid
    task automatic send(input logic rq, input logic [14:0] mv, input bit counted);
        @(negedge clk);
        if (!no_gaps && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        target_mv <= mv;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (counted)
            items_sent++;
    endtask

    // Drop valid, wait for every result, then let the pipeline empty
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic configure(input bit extra);
        for (int r = REG_LEAD_HIGH; r <= REG_SETTLE; r++)
            write_reg(r[CFG_IDX_W-1:0], seg_ms[r]);
        if (extra)
            write_reg(REG_UNUSED, 8'($urandom_range(255)));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Ticks of one pattern, with the odd start while busy mixed in
    task automatic run_ticks(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 5)
                send(REQ_START, 15'($urandom_range(32767)), 1'b1);
            send(REQ_TICK, 15'($urandom_range(32767)), 1'b1);
        end
    endtask

    task automatic idle_noise();
        repeat ($urandom_range(0, 3))
        begin
            case ($urandom_range(2))
                0: send(REQ_TICK, 15'($urandom_range(32767)), 1'b0);
                1: send(REQ_START, 15'($urandom_range(0, MIN_MV - 1)), 1'b1);
                default: send(REQ_START, 15'($urandom_range(MAX_MV + 1, 32767)), 1'b1);
            endcase
        end
    endtask

    initial
    begin
        int phase_no;
        int big;
        int n_pat;
        seg_ms = '{LEAD_HIGH_RST, LEAD_LOW_RST, SHORT_RST, LONG_RST,
                   STOP_RST, GAP_RST, SETTLE_RST};
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed: idle tick, window edges, start while busy
        send(REQ_TICK, 15'h7FFF, 1'b1);
        send(REQ_START, MIN_MV - 1'b1, 1'b1);
        send(REQ_START, MAX_MV + 1'b1, 1'b1);
        send(REQ_START, 15'd0, 1'b1);
        send(REQ_START, 15'h7FFF, 1'b1);
        send(REQ_START, MIN_MV, 1'b1);
        send(REQ_START, MAX_MV, 1'b1);
        // Zero lengths written mid-pattern take effect from the next segment on
        drain();
        foreach (seg_ms[r])
            seg_ms[r] = 8'd0;
        configure(1'b1);
        run_ticks(pattern_ticks());
        send(REQ_TICK, 15'd0, 1'b1);

        phase_no = 0;
        while (items_sent < ITEMS)
        begin
            drain();
            no_gaps = (phase_no == 1);
            big = ($urandom_range(99) < 30 || phase_no == 3) ? $urandom_range(6) : -1;
            // A long bit segment repeats for every code bit; stretch a single segment
            if (big == int'(REG_SHORT) || big == int'(REG_LONG))
                big = int'(REG_STOP);
            foreach (seg_ms[r])
            begin
                if (r == big)
                    seg_ms[r] = 8'd255;
                else if ($urandom_range(99) < 15)
                    seg_ms[r] = 8'($urandom_range(4, 12));
                else
                    seg_ms[r] = 8'($urandom_range(0, 3));
            end
            configure($urandom_range(99) < 20);
            if (phase_no == 2)
                hold_go = 1'b1;
            n_pat = (big >= 0) ? 1 : $urandom_range(1, 3);
            repeat (n_pat)
            begin
                send(REQ_START, pick_target(), 1'b1);
                run_ticks(pattern_ticks());
                idle_noise();
            end
            phase_no++;
        end

        drain();
        repeat (10) @(negedge clk);
        if (chk_errors == 0)
            $display("** charger_current_pulse_encoder: PASSED **");
        else
            $display("** charger_current_pulse_encoder: FAILED **");
        $finish;
    end

endmodule
